// File: design/clbe_pkg.sv
// package for the controller link and button event block
// shared constants, types and small lookup functions; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package clbe_pkg;

    localparam int MAX_BUTTONS      = 8;
    localparam int MAX_RESULTS      = 8;
    localparam int DEF_NUM_BUTTONS  = 8;
    localparam int DEF_TIME_WIDTH   = 48;
    localparam int DEF_HASH_WIDTH   = 64;
    localparam int HASH_PORT_W      = 64;
    localparam int TIME_PORT_W      = 48;
    localparam int WIN_W            = 16;
    localparam int CAP_W            = 4;
    localparam int CFG_DATA_W       = 16;

    localparam logic [WIN_W-1:0] WIN_RESET = 16'd1000;
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;
    localparam logic [CAP_W-1:0] CAP_MAX   = 4'(MAX_RESULTS);

    typedef enum logic
    {
        CFG_LIVE_WINDOW = 1'b0,
        CFG_EVENT_CAP   = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0]
    {
        EV_ENTER    = 2'd0,
        EV_BACK     = 2'd1,
        EV_SUMMON   = 2'd2,
        EV_RECENTER = 2'd3
    } event_code_t;

    // pointer owner, two's complement: minus one means none
    typedef logic [1:0] owner_t;
    localparam owner_t OWNER_LEFT  = 2'b00;
    localparam owner_t OWNER_RIGHT = 2'b01;
    localparam owner_t OWNER_NONE  = 2'b11;

    typedef struct packed
    {
        logic [MAX_BUTTONS-1:0] edges;
        logic [MAX_BUTTONS-1:0] buttons;
        owner_t                 owner;
        logic [1:0]             link;
    } tick_result_t;

    function automatic event_code_t button_code(input logic [2:0] b);
        event_code_t code;
        unique case (b) inside
            3'd0, 3'd1, 3'd6, 3'd7: code = EV_ENTER;
            3'd2, 3'd3:             code = EV_BACK;
            3'd4:                   code = EV_SUMMON;
            3'd5:                   code = EV_RECENTER;
            default:                code = EV_ENTER;
        endcase
        return code;
    endfunction

    function automatic logic [2:0] lowest_set(input logic [MAX_BUTTONS-1:0] mask);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = MAX_BUTTONS - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: design/clbe_ifs.sv
// valid/ready channel interfaces for tick items and event items
// depends on clbe_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface clbe_tick_if;
    logic                                valid;
    logic                                ready;
    logic                                controller;
    logic [clbe_pkg::HASH_PORT_W-1:0]    block_hash;
    logic [clbe_pkg::MAX_BUTTONS-1:0]    button_bits;
    logic [clbe_pkg::TIME_PORT_W-1:0]    now_ms;

    modport source (output valid, controller, block_hash, button_bits, now_ms, input ready);
    modport sink   (input valid, controller, block_hash, button_bits, now_ms, output ready);
endinterface

interface clbe_event_if;
    logic              valid;
    logic              ready;
    logic              has_event;
    logic [1:0]        event_code;
    logic              pressed;
    logic signed [1:0] active_controller;
    logic              left_connected;
    logic              right_connected;
    logic              last;

    modport source (output valid, has_event, event_code, pressed, active_controller,
                    left_connected, right_connected, last, input ready);
    modport sink   (input valid, has_event, event_code, pressed, active_controller,
                    left_connected, right_connected, last, output ready);
endinterface

`default_nettype wire

// File: design/clbe_track.sv
// per-controller hash tracking, link state, pointer owner and button edges
// depends on clbe_pkg; state advances on the go strobe
`timescale 1ns / 1ps
`default_nettype none

module clbe_track #(
    parameter int NUM_BUTTONS = clbe_pkg::DEF_NUM_BUTTONS,
    parameter int TIME_WIDTH  = clbe_pkg::DEF_TIME_WIDTH,
    parameter int HASH_WIDTH  = clbe_pkg::DEF_HASH_WIDTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              go,
    input  wire logic                              controller,
    input  wire logic [clbe_pkg::HASH_PORT_W-1:0]  block_hash,
    input  wire logic [clbe_pkg::MAX_BUTTONS-1:0]  button_bits,
    input  wire logic [clbe_pkg::TIME_PORT_W-1:0]  now_ms,
    input  wire logic [clbe_pkg::WIN_W-1:0]        live_window,
    output clbe_pkg::tick_result_t                 result
);

    localparam int NB = (NUM_BUTTONS < clbe_pkg::MAX_BUTTONS) ? NUM_BUTTONS
                                                              : clbe_pkg::MAX_BUTTONS;
    localparam logic [clbe_pkg::MAX_BUTTONS-1:0] BTN_MASK =
        clbe_pkg::MAX_BUTTONS'((1 << NB) - 1);
    localparam int CTW = TIME_WIDTH + 1;
    localparam int DW  = TIME_WIDTH + 2;

    logic [HASH_WIDTH-1:0]  last_hash_reg [2];
    logic [HASH_WIDTH-1:0]  last_hash_next;
    logic signed [CTW-1:0]  change_time_reg [2];
    logic signed [CTW-1:0]  change_time_next;
    logic [1:0]             seen_reg;
    logic [1:0]             link_reg;
    logic [1:0]             link_next;
    clbe_pkg::owner_t       owner_reg;
    clbe_pkg::owner_t       owner_next;
    logic [NB-1:0]          prev_reg [2];
    logic [NB-1:0]          prev_next;

    logic                   which;
    logic                   other;
    logic [HASH_WIDTH-1:0]  hash;
    logic                   changed;
    logic                   seen_old;
    logic [TIME_WIDTH-1:0]  now;
    logic signed [CTW-1:0]  ct_first;
    logic signed [DW-1:0]   diff;
    logic signed [DW-1:0]   win_ext;
    logic                   live;
    logic [clbe_pkg::MAX_BUTTONS-1:0] btn8;
    logic [clbe_pkg::MAX_BUTTONS-1:0] prev8;
    logic [clbe_pkg::MAX_BUTTONS-1:0] edges;

    assign which    = controller;
    assign other    = ~controller;
    assign hash     = block_hash[HASH_WIDTH-1:0];
    assign changed  = hash != last_hash_reg[which];
    assign seen_old = seen_reg[which];
    assign now      = TIME_WIDTH'(now_ms);

    // first change is back-dated by one window
    assign ct_first = $signed({1'b0, now}) - $signed(CTW'(live_window));
    assign diff     = $signed({2'b00, now}) - $signed({change_time_reg[which][CTW-1],
                                                      change_time_reg[which]});
    assign win_ext  = $signed(DW'(live_window));

    // on a change the new age is zero when seen before, else exactly one window
    assign live = changed ? (seen_old && (live_window != '0))
                          : (seen_old && (diff < win_ext));

    assign last_hash_next   = hash;
    assign change_time_next = seen_old ? $signed({1'b0, now}) : ct_first;
    assign btn8             = button_bits & BTN_MASK;
    assign prev8            = clbe_pkg::MAX_BUTTONS'(prev_reg[which]);

    always_comb
    begin
        link_next  = link_reg;
        owner_next = owner_reg;
        edges      = '0;
        if (live && !link_reg[which])
        begin
            link_next[which] = 1'b1;
            if (owner_reg == clbe_pkg::OWNER_NONE)
            begin
                owner_next = clbe_pkg::owner_t'({1'b0, which});
            end
        end
        else if (!live && link_reg[which])
        begin
            link_next[which] = 1'b0;
            if (owner_reg == clbe_pkg::owner_t'({1'b0, which}))
            begin
                owner_next = link_reg[other] ? clbe_pkg::owner_t'({1'b0, other})
                                             : clbe_pkg::OWNER_NONE;
            end
        end
        if (link_next[which])
        begin
            edges = btn8 ^ prev8;
            if ((btn8 & ~prev8) != '0)
            begin
                owner_next = clbe_pkg::owner_t'({1'b0, which});
            end
        end
    end

    assign prev_next = link_next[which] ? btn8[NB-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_hash_reg[0]   <= '0;
            last_hash_reg[1]   <= '0;
            change_time_reg[0] <= '0;
            change_time_reg[1] <= '0;
            seen_reg           <= '0;
            link_reg           <= '0;
            owner_reg          <= clbe_pkg::OWNER_NONE;
            prev_reg[0]        <= '0;
            prev_reg[1]        <= '0;
        end
        else if (go)
        begin
            if (changed)
            begin
                last_hash_reg[which]   <= last_hash_next;
                change_time_reg[which] <= change_time_next;
                seen_reg[which]        <= 1'b1;
            end
            link_reg        <= link_next;
            owner_reg       <= owner_next;
            prev_reg[which] <= prev_next;
        end
    end

    assign result.edges   = edges;
    assign result.buttons = btn8;
    assign result.owner   = owner_next;
    assign result.link    = link_next;

endmodule

`default_nettype wire

// File: design/clbe_events.sv
// result register that drains one tick's button edges in button order
// depends on clbe_pkg and clbe_event_if; one item per cycle while ev.ready is high
`timescale 1ns / 1ps
`default_nettype none

module clbe_events (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire clbe_pkg::tick_result_t      result,
    input  wire logic [clbe_pkg::CAP_W-1:0]  event_cap,
    output logic                             free,
    clbe_event_if.source                     ev
);

    logic                                valid_reg;
    logic [clbe_pkg::MAX_BUTTONS-1:0]    mask_reg;
    logic [clbe_pkg::MAX_BUTTONS-1:0]    btn_reg;
    logic [clbe_pkg::CAP_W-1:0]          left_reg;
    logic                                status_reg;
    clbe_pkg::owner_t                    owner_reg;
    logic [1:0]                          link_reg;

    logic [clbe_pkg::CAP_W-1:0]          cap_eff;
    logic [2:0]                          idx;
    logic [clbe_pkg::MAX_BUTTONS-1:0]    rest;
    logic                                last_c;
    logic                                take;

    assign cap_eff = (event_cap > clbe_pkg::CAP_MAX) ? clbe_pkg::CAP_MAX : event_cap;
    assign idx     = clbe_pkg::lowest_set(mask_reg);
    assign rest    = mask_reg & ~(clbe_pkg::MAX_BUTTONS'(1) << idx);
    assign last_c  = status_reg || (rest == '0) || (left_reg == clbe_pkg::CAP_W'(1));
    assign take    = valid_reg && ev.ready;
    assign free    = !valid_reg || (ev.ready && last_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (take && last_c)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mask_reg   <= result.edges;
            btn_reg    <= result.buttons;
            left_reg   <= cap_eff;
            // nothing to report: one status-only item
            status_reg <= (result.edges == '0) || (cap_eff == '0);
            owner_reg  <= result.owner;
            link_reg   <= result.link;
        end
        else if (take && !last_c)
        begin
            mask_reg <= rest;
            left_reg <= left_reg - clbe_pkg::CAP_W'(1);
        end
    end

    assign ev.valid             = valid_reg;
    assign ev.has_event         = !status_reg;
    assign ev.event_code        = status_reg ? clbe_pkg::EV_ENTER : clbe_pkg::button_code(idx);
    assign ev.pressed           = !status_reg && btn_reg[idx];
    assign ev.active_controller = $signed(owner_reg);
    assign ev.left_connected    = link_reg[0];
    assign ev.right_connected   = link_reg[1];
    assign ev.last              = last_c;

endmodule

`default_nettype wire

// File: design/controller_link_and_button_events.sv
// top level: input register, config registers, tracker and event drain
// an accepted tick waits in the input register, then loads into the result register
// once the drain is free; a tick gives max(1, events) items, at most 8, drained
// at one item per cycle while ready is high; the input register overlaps the drain
// reset: links down, no owner, hashes, times and buttons cleared, window 1000, cap 8
// depends on clbe_pkg, clbe_ifs, clbe_track, clbe_events
`timescale 1ns / 1ps
`default_nettype none

module controller_link_and_button_events #(
    parameter int NUM_BUTTONS = clbe_pkg::DEF_NUM_BUTTONS,
    parameter int TIME_WIDTH  = clbe_pkg::DEF_TIME_WIDTH,
    parameter int HASH_WIDTH  = clbe_pkg::DEF_HASH_WIDTH
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic                             cfg_index,
    input  wire logic [clbe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    clbe_tick_if.sink                             tick_in,
    clbe_event_if.source                          event_out
);

    logic                                in_valid_reg;
    logic                                controller_reg;
    logic [clbe_pkg::HASH_PORT_W-1:0]    hash_reg;
    logic [clbe_pkg::MAX_BUTTONS-1:0]    buttons_reg;
    logic [clbe_pkg::TIME_PORT_W-1:0]    now_reg;
    logic [clbe_pkg::WIN_W-1:0]          window_reg;
    logic [clbe_pkg::CAP_W-1:0]          cap_reg;

    logic                                accept;
    logic                                load;
    logic                                free;
    clbe_pkg::tick_result_t              result;

    assign load          = in_valid_reg && free;
    assign tick_in.ready = !in_valid_reg || load;
    assign accept        = tick_in.valid && tick_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            window_reg   <= clbe_pkg::WIN_RESET;
            cap_reg      <= clbe_pkg::CAP_RESET;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (load)
            begin
                in_valid_reg <= 1'b0;
            end
            if (cfg_wr_en)
            begin
                unique case (clbe_pkg::cfg_index_t'(cfg_index))
                    clbe_pkg::CFG_LIVE_WINDOW: window_reg <= cfg_wdata[clbe_pkg::WIN_W-1:0];
                    clbe_pkg::CFG_EVENT_CAP:   cap_reg    <= cfg_wdata[clbe_pkg::CAP_W-1:0];
                    default:                   cap_reg    <= cap_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            controller_reg <= tick_in.controller;
            hash_reg       <= tick_in.block_hash;
            buttons_reg    <= tick_in.button_bits;
            now_reg        <= tick_in.now_ms;
        end
    end

    clbe_track #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .TIME_WIDTH  (TIME_WIDTH),
        .HASH_WIDTH  (HASH_WIDTH)
    ) u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (load),
        .controller  (controller_reg),
        .block_hash  (hash_reg),
        .button_bits (buttons_reg),
        .now_ms      (now_reg),
        .live_window (window_reg),
        .result      (result)
    );

    clbe_events u_events (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .result    (result),
        .event_cap (cap_reg),
        .free      (free),
        .ev        (event_out)
    );

endmodule

`default_nettype wire

// File: design/clbe_checker.sv
// port-level checks for controller_link_and_button_events, bound to the top
// depends on clbe_pkg for the owner codes
`timescale 1ns / 1ps
`default_nettype none

module clbe_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              has_event,
    input wire logic              pressed,
    input wire logic signed [1:0] active_controller,
    input wire logic              left_connected,
    input wire logic              right_connected,
    input wire logic              last
);

    // a waiting item stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item withdrawn before it was taken");

    // a status-only item is always the only item of its tick
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_event |-> last)
        else $error("status item not marked last");

    // a press always leaves an owner
    a_press_owner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_event && pressed |->
            active_controller != $signed(clbe_pkg::OWNER_NONE))
        else $error("press item without a pointer owner");

    // the owner is always a connected controller
    a_owner_left: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && active_controller == $signed(clbe_pkg::OWNER_LEFT) |-> left_connected)
        else $error("left owns pointer while disconnected");

    a_owner_right: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && active_controller == $signed(clbe_pkg::OWNER_RIGHT) |-> right_connected)
        else $error("right owns pointer while disconnected");

endmodule

bind controller_link_and_button_events clbe_checker u_clbe_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (event_out.valid),
    .out_ready         (event_out.ready),
    .has_event         (event_out.has_event),
    .pressed           (event_out.pressed),
    .active_controller (event_out.active_controller),
    .left_connected    (event_out.left_connected),
    .right_connected   (event_out.right_connected),
    .last              (event_out.last)
);

`default_nettype wire
